// File: hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address resolution cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int SLOT_W    = 5;
	localparam int CNT_W     = 6;
	localparam int TICK_W    = 32;
	localparam int TIMEOUT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd15;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_TICK   = 2'd2
	} mode_t;

	// one beat travelling down the row of entries, with its running results
	typedef struct packed {
		logic              valid;
		mode_t             mode;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [TICK_W-1:0] now;
		logic              hit;
		logic [MAC_W-1:0]  mac_out;
		logic [SLOT_W-1:0] slot;
		logic              stored;
		logic [CNT_W-1:0]  expired;
	} beat_t;

endpackage

// File: hw/rtl/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One table entry: holds address, MAC, stamp and valid mark, applies the
// passing beat to its entry and hands the updated beat to the next cell.
// ----------------------------------------------------------------------------
module arpc_cell
	import arpc_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [TIMEOUT_W-1:0] timeout,
	input  beat_t                beat_in,
	output beat_t                beat_out
);

	logic              valid_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TICK_W-1:0] stamp_q;
	beat_t             beat_s1;
	beat_t             beat_nxt;
	logic [TICK_W-1:0] age;
	logic              do_write;
	logic              do_expire;

	assign age = beat_in.now - stamp_q;

	always_comb begin
		beat_nxt  = beat_in;
		do_write  = 1'b0;
		do_expire = 1'b0;
		case (beat_in.mode)
			MODE_LOOKUP: begin
				if (valid_q && (ip_q == beat_in.ip)) begin
					beat_nxt.hit     = 1'b1;
					beat_nxt.mac_out = mac_q;
					beat_nxt.slot    = SLOT_W'(CELL_IDX);
				end
			end
			MODE_INSERT: begin
				if (!valid_q && !beat_in.stored) begin
					beat_nxt.stored = 1'b1;
					beat_nxt.slot   = SLOT_W'(CELL_IDX);
					do_write        = beat_in.valid;
				end
			end
			MODE_TICK: begin
				if (valid_q && (age > {{(TICK_W-TIMEOUT_W){1'b0}}, timeout})) begin
					beat_nxt.expired = beat_in.expired + CNT_W'(1);
					do_expire        = beat_in.valid;
				end
			end
			default: begin
				beat_nxt = beat_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			if (do_write) begin
				valid_q <= 1'b1;
			end else if (do_expire) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && do_write) begin
			ip_q    <= beat_in.ip;
			mac_q   <= beat_in.mac;
			stamp_q <= beat_in.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
		end else if (advance) begin
			beat_s1 <= beat_nxt;
		end
	end

	assign beat_out = beat_s1;

endmodule

// File: hw/rtl/arp_cache_table_with_aging.sv
// each beat is registered in every entry cell in turn and then in the output register
// throughput: one beat per cycle while the result is not stalled, items flow down the row of entry cells
// a stalled result freezes the whole row and stalls the input
// reset clears all valid marks, the tick count and the output valid flag
// timeout resets to 15 ticks
// ----------------------------------------------------------------------------
// arp_cache_table_with_aging
// IPv4 to MAC cache with lookup, insert into lowest free entry and tick aging,
// built as a row of entry cells that each beat passes through in order.
// ----------------------------------------------------------------------------
module arp_cache_table_with_aging
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TIMEOUT_W-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [IP_W-1:0]      ip_addr,
	input  logic [MAC_W-1:0]     mac_addr,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic [MAC_W-1:0]     mac_out,
	output logic [SLOT_W-1:0]    slot,
	output logic                 stored,
	output logic [CNT_W-1:0]     expired_count
);

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TICK_W-1:0]    now_q;
	logic                 out_valid_q;
	beat_t                res_q;
	logic                 advance;
	logic                 in_accept;
	logic                 is_tick;
	beat_t                head;
	beat_t                chain [ENTRIES+1];

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = !advance;
	assign in_accept = in_valid && advance;
	assign is_tick   = (mode_t'(mode) == MODE_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (in_accept && is_tick) begin
			now_q <= now_q + TICK_W'(1);
		end
	end

	always_comb begin
		head         = '0;
		head.valid   = in_valid;
		head.mode    = mode_t'(mode);
		head.ip      = ip_addr;
		head.mac     = mac_addr;
		head.now     = is_tick ? (now_q + TICK_W'(1)) : now_q;
	end

	assign chain[0] = head;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		arpc_cell #(
			.CELL_IDX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.timeout  (timeout_q),
			.beat_in  (chain[g]),
			.beat_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain[ENTRIES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= chain[ENTRIES];
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = res_q.hit;
	assign mac_out       = res_q.mac_out;
	assign slot          = res_q.slot;
	assign stored        = res_q.stored;
	assign expired_count = res_q.expired;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

	a_hit_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.hit && res_q.stored))
		else $error("result both hit and stored");

	a_expire_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.expired != '0)) |-> (res_q.mode == MODE_TICK))
		else $error("expiry reported for a non-tick item");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && is_tick) |=> (now_q == $past(now_q) + TICK_W'(1)))
		else $error("tick count did not advance");

endmodule
